>>> rtl/srpq_pkg.sv
// Shared types and constants for the sorted ring priority queue.
// Holds the command and status codes, field widths and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srpq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_ENQ  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

endpackage : srpq_pkg

`default_nettype wire

>>> rtl/sorted_ring_priority_queue_unit.sv
// Sorted ring priority queue: top level with ring memory and insertion sequencer.
// Depends on srpq_pkg for codes, widths and the state type.
//
// Usage: transactions enter on the slave stream. tuser[0] is the command
// (0 enqueue tdata[31:0], 1 dequeue the largest entry). Every input transaction
// produces exactly one result transaction on the master stream: tdata carries
// the dequeued value (or -1) in bits 31:0 and the occupancy after the item in
// bits 36:32, and tuser carries the status (done, full, empty).
// Entries live in a ring memory in descending order starting at a head pointer,
// so a dequeue only reads the head and advances it. An enqueue walks from the
// tail toward the head, reading one entry per cycle through the synchronous
// memory and moving each smaller entry one slot back until the insertion point
// is found. Equal values stay in arrival order.
// Sequencing: the block works on one transaction at a time. A dequeue passes
// through S_DEQ and S_RESP before it is ready again, a rejected or empty item
// through S_RESP alone, and an enqueue stays in S_ENQ while it moves each held
// entry smaller than the new value, then writes it; the single read port paces the walk.
// When the receiver stalls, the result waits in the output register while the
// next transaction is accepted and processed; it then waits in the sequencer.
// Reset empties the queue (count and head cleared); memory contents are not
// cleared and are never used before being written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_ring_priority_queue_unit
  import srpq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] data, [36:32] occupancy, zero pad
  output logic [1:0]       m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = (CW > OCC_W) ? CW : OCC_W;

  // Ring pointer helpers; DEPTH need not be a power of two.
  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) r = AW'(DEPTH - 1);
    else         r = p - AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) r = '0;
    else                     r = p + AW'(1);
    return r;
  endfunction

  // Ring memory with registered read data.
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] mem_rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // Control and payload registers.
  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  status_e           res_status_q, res_status_d;

  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q, m_data_d;
  logic [OCC_W-1:0]  m_occ_q, m_occ_d;
  status_e           m_status_q, m_status_d;

  logic              s_accept;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail_ptr;
  logic [OW-1:0]     count_ext;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Physical slot just past the last valid entry.
  assign tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
  assign tail_ptr = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                   : tail_sum[AW-1:0];
  assign count_ext = OW'(count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    rem_d        = rem_q;
    val_d        = val_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = wr_ptr_q;
    mem_wdata    = val_q;
    mem_raddr    = head_q;

    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    m_occ_d    = m_occ_q;
    m_status_d = m_status_q;

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          val_d      = s_axis_tdata_i;
          res_data_d = MINUS_ONE;
          if (s_axis_tuser_i[0] == CMD_DEQUEUE) begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              // Head is read this cycle; data arrives in S_DEQ.
              res_status_d = ST_DONE;
              state_d      = S_DEQ;
            end
          end else begin
            if (count_q == CW'(DEPTH)) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else begin
              res_status_d = ST_DONE;
              wr_ptr_d     = tail_ptr;
              rd_ptr_d     = ptr_dec(tail_ptr);
              mem_raddr    = ptr_dec(tail_ptr);
              rem_d        = count_q;
              state_d      = S_ENQ;
            end
          end
        end
      end

      S_DEQ: begin
        res_data_d = mem_rdata_q;
        head_d     = ptr_inc(head_q);
        count_d    = count_q - CW'(1);
        state_d    = S_RESP;
      end

      S_ENQ: begin
        mem_we = 1'b1;
        if ((rem_q != '0) && ($signed(mem_rdata_q) < $signed(val_q))) begin
          // Move the smaller entry one slot toward the tail and fetch the next one.
          mem_wdata = mem_rdata_q;
          wr_ptr_d  = rd_ptr_q;
          rd_ptr_d  = ptr_dec(rd_ptr_q);
          mem_raddr = ptr_dec(rd_ptr_q);
          rem_d     = rem_q - CW'(1);
        end else begin
          mem_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = S_RESP;
        end
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_data_d   = res_data_q;
          m_status_d = res_status_q;
          m_occ_d    = count_ext[OCC_W-1:0];
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      head_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      head_q    <= head_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q     <= wr_ptr_d;
    rd_ptr_q     <= rd_ptr_d;
    rem_q        <= rem_d;
    val_q        <= val_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
    m_occ_q      <= m_occ_d;
    m_status_q   <= m_status_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, m_occ_q, m_data_q};
  assign m_axis_tuser_o  = m_status_q;

  // The queue never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  // The insertion walk never looks past the head of the queue.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENQ) |-> (rem_q < CW'(DEPTH)) && (count_q < CW'(DEPTH)))
    else $error("insertion walk out of range");

  // An empty result reports no entries and the -1 marker.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q == ST_EMPTY)) |-> (m_occ_q == '0) && (m_data_q == MINUS_ONE))
    else $error("empty result with entries or data");

  // A full rejection reports the queue at capacity. The live count may already
  // have moved on while the result waits, so only the captured fields are checked.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q == ST_FULL)) |->
      (m_occ_q == OCC_W'(DEPTH)) && (m_data_q == MINUS_ONE))
    else $error("full result while queue not at capacity");

endmodule : sorted_ring_priority_queue_unit

`default_nettype wire
